/* rtl/core/ssrp_pkg.sv */
// shared types and constants for the servo sequence record parser
// no dependencies; imported by every module of the block

package ssrp_pkg;

  localparam int unsigned RecBytes = 10;
  localparam int unsigned AsmBytes = RecBytes - 1;
  localparam int unsigned PosW     = 4;
  localparam int unsigned AddrW    = 2;

  typedef enum logic [2:0] {
    ST_RECORD   = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_MISMATCH = 3'd2,
    ST_RANGE    = 3'd3,
    ST_ORDER    = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    PH_IDLE     = 5'b00001,
    PH_COUNT_LO = 5'b00010,
    PH_COUNT_HI = 5'b00100,
    PH_RECORD   = 5'b01000,
    PH_DONE     = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  servo_index;
    logic [23:0] start_time;
    logic [23:0] end_time;
    logic [11:0] start_position;
    logic [11:0] end_position;
    logic        last_record;
  } out_item_t;

endpackage

/* rtl/core/ssrp_cfg.sv */
// configuration register file: servo_count behind an apb-style port
// depends on ssrp_pkg

module ssrp_cfg import ssrp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [7:0]       servo_count
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      servo_count <= 8'd0;
    end else if (wr_en) begin
      servo_count <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[AddrW-1:0] == '0) begin
      prdata = {24'd0, servo_count};
    end
  end

endmodule

/* rtl/core/ssrp_parse.sv */
// byte parser: frame state, record assembly and error checks
// depends on ssrp_pkg

module ssrp_parse import ssrp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  in_item_t   item,
  input  logic [7:0] servo_count,
  output logic       res_valid,
  output out_item_t  res
);

  phase_t            phase, phase_next;
  logic [PosW-1:0]   byte_position, byte_position_next;
  logic [15:0]       steps_remaining, steps_remaining_next;
  logic [23:0]       previous_start_time, previous_start_time_next;
  logic [7:0]        rec [AsmBytes];
  logic              asm_we;
  logic [PosW-1:0]   pos;
  logic [7:0]        b;
  logic [23:0]       st;
  logic [15:0]       steps_full;

  assign b          = item.data_byte;
  assign pos        = (byte_position > PosW'(RecBytes - 1)) ? '0 : byte_position;
  assign st         = {b, rec[2], rec[1]};
  assign steps_full = {b, steps_remaining[7:0]};

  always_comb begin
    phase_next               = phase;
    byte_position_next       = byte_position;
    steps_remaining_next     = steps_remaining;
    previous_start_time_next = previous_start_time;
    asm_we                   = 1'b0;
    res_valid                = 1'b0;
    res                      = '0;
    if (accept) begin
      if (item.frame_start) begin
        byte_position_next       = '0;
        steps_remaining_next     = 16'd0;
        previous_start_time_next = 24'd0;
        if (b != servo_count) begin
          phase_next = PH_DONE;
          res_valid  = 1'b1;
          res.status = ST_MISMATCH;
        end else begin
          phase_next = PH_COUNT_LO;
        end
      end else begin
        case (phase)
          PH_COUNT_LO: begin
            steps_remaining_next = {8'd0, b};
            phase_next           = PH_COUNT_HI;
          end
          PH_COUNT_HI: begin
            steps_remaining_next = steps_full;
            if (steps_full == 16'd0) begin
              phase_next = PH_DONE;
              res_valid  = 1'b1;
              res.status = ST_EMPTY;
            end else begin
              phase_next         = PH_RECORD;
              byte_position_next = '0;
            end
          end
          PH_RECORD: begin
            asm_we = (pos < PosW'(AsmBytes));
            if (pos == '0 && b >= servo_count) begin
              phase_next         = PH_DONE;
              byte_position_next = pos;
              res_valid          = 1'b1;
              res.status         = ST_RANGE;
            end else if (pos == PosW'(3) && st < previous_start_time) begin
              phase_next         = PH_DONE;
              byte_position_next = pos;
              res_valid          = 1'b1;
              res.status         = ST_ORDER;
            end else if (pos < PosW'(RecBytes - 1)) begin
              byte_position_next = pos + PosW'(1);
              if (pos == PosW'(3)) begin
                previous_start_time_next = st;
              end
            end else begin
              byte_position_next   = '0;
              steps_remaining_next = steps_remaining - 16'd1;
              res_valid            = 1'b1;
              res.status           = ST_RECORD;
              res.servo_index      = rec[0];
              res.start_time       = {rec[3], rec[2], rec[1]};
              res.end_time         = {rec[6], rec[5], rec[4]};
              res.start_position   = {rec[7], rec[8][7:4]};
              res.end_position     = {b, rec[8][3:0]};
              res.last_record      = (steps_remaining_next == 16'd0);
              if (steps_remaining_next == 16'd0) begin
                phase_next = PH_DONE;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= PH_IDLE;
      byte_position       <= '0;
      steps_remaining     <= 16'd0;
      previous_start_time <= 24'd0;
    end else begin
      phase               <= phase_next;
      byte_position       <= byte_position_next;
      steps_remaining     <= steps_remaining_next;
      previous_start_time <= previous_start_time_next;
    end
  end

  always_ff @(posedge clk) begin
    if (asm_we) begin
      rec[pos] <= b;
    end
  end

`ifndef NO_ASSERTIONS
  a_err_fields_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status != ST_RECORD |->
      res.servo_index == 8'd0 && res.start_time == 24'd0 && res.last_record == 1'b0)
    else $error("error result carries nonzero fields");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    accept && item.frame_start |=> phase == PH_COUNT_LO || phase == PH_DONE)
    else $error("frame start did not restart the frame");

  a_result_ends_frame: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status != ST_RECORD |=> phase == PH_DONE)
    else $error("error or completion did not end the frame");
`endif

endmodule

/* rtl/core/ssrp_obuf.sv */
// two-entry result buffer: output register plus skid entry
// depends on ssrp_pkg

module ssrp_obuf import ssrp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  out_item_t din,
  output logic      full,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      head_valid, skid_valid;
  out_item_t head, skid;
  logic      pop;

  assign pop       = head_valid && !out_stall;
  assign full      = skid_valid;
  assign out_valid = head_valid;
  assign out_data  = head;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= push;
      end else begin
        head_valid <= push;
      end
    end else if (push) begin
      if (!head_valid) begin
        head_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        head <= skid;
        skid <= din;
      end else begin
        head <= din;
      end
    end else if (push) begin
      if (!head_valid) begin
        head <= din;
      end else begin
        skid <= din;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !skid_valid || pop)
    else $error("push into full result buffer");

  a_skid_behind_head: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> head_valid)
    else $error("skid entry valid with empty head");

  a_skid_moves_up: assert property (@(posedge clk) disable iff (rst)
    pop && skid_valid |=> head_valid && head == $past(skid))
    else $error("skid entry lost on head transfer");
`endif

endmodule

/* rtl/core/servo_sequence_record_parser.sv */
// top level of the servo sequence record parser
// depends on ssrp_pkg, ssrp_cfg, ssrp_parse, ssrp_obuf
//
//   channel  | handshake           | payload
//   ---------+---------------------+------------------------------
//   in       | in_valid / in_stall | in_data   (in_item_t, 1 byte)
//   out      | out_valid/out_stall | out_data  (out_item_t)
//   cfg      | psel/penable/pready | paddr, pwdata, prdata
//
// one byte is taken per cycle unless in_stall is high; out_data is a buffer register
// the parser state updates at the byte transfer, results queue in a two-entry buffer
// in_stall is high while both buffer entries hold results, whether out stalls or not
// reset is synchronous; it clears the frame state, the buffer and servo_count

module servo_sequence_record_parser import ssrp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic      [7:0] servo_count;
  logic            accept;
  logic            res_valid;
  out_item_t       res;
  logic            full;

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  ssrp_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .servo_count (servo_count)
  );

  ssrp_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .item        (in_data),
    .servo_count (servo_count),
    .res_valid   (res_valid),
    .res         (res)
  );

  ssrp_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .din       (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
